/* hdl/rpn_pkg.sv */
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and codes for the RPN stack calculator: command and status
// codes, arithmetic unit operations and the request/response bundles.
// ----------------------------------------------------------------------------
package rpn_pkg;

    // command codes
    localparam logic [2:0] CMD_PUSH  = 3'd0;
    localparam logic [2:0] CMD_ADD   = 3'd1;
    localparam logic [2:0] CMD_SUB   = 3'd2;
    localparam logic [2:0] CMD_MUL   = 3'd3;
    localparam logic [2:0] CMD_DIV   = 3'd4;
    localparam logic [2:0] CMD_CLEAR = 3'd5;
    localparam logic [2:0] CMD_PEEK  = 3'd6;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_UNDER      = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_DIV0       = 3'd3;
    localparam logic [2:0] ST_SAT        = 3'd4;
    localparam logic [2:0] ST_PEEK_EMPTY = 3'd5;

    localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [2:0]  status;
        logic [31:0] value;
    } t_alu_rsp;

endpackage

/* hdl/rpn_ram.sv */
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/rpn_alu.sv */
// ----------------------------------------------------------------------------
// rpn_alu
// Iterative fixed-point arithmetic unit. One shared 33-bit adder serves
// add/sub, shift-add multiply and restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module rpn_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rpn_pkg::t_alu_req   i_req,
    input  logic signed [31:0]  i_a,
    input  logic signed [31:0]  i_b,
    output rpn_pkg::t_alu_rsp   o_rsp
);
    import rpn_pkg::*;

    localparam logic signed [64:0] HALF = $signed((65'd1 << FRAC_BITS) >> 1);
    localparam logic signed [64:0] SMAX = $signed({33'd0, VAL_MAX});
    localparam logic signed [64:0] SMIN = $signed({{33{1'b1}}, VAL_MIN});

    typedef enum logic [3:0] {
        A_IDLE, A_ADD, A_ABS, A_PREP, A_DIV, A_MUL, A_MNEG, A_MRND, A_DFIN
    } t_state;

    t_state             r_state;
    t_alu_op            r_op;
    logic signed [31:0] r_a;
    logic signed [31:0] r_b;
    logic [31:0]        r_amag;
    logic [31:0]        r_bmag;
    logic               r_neg;
    logic               r_ovf;
    logic [31:0]        r_hi;
    logic [31:0]        r_lo;
    logic [4:0]         r_cnt;
    logic signed [64:0] r_prod;
    logic               r_done;
    logic [31:0]        r_value;
    logic [2:0]         r_status;

    logic [32:0]        w_add_a;
    logic [32:0]        w_add_b;
    logic               w_cin;
    logic [33:0]        w_sum;
    logic               w_ge;
    logic [31:0]        w_amag;
    logic [31:0]        w_bmag;
    logic [63:0]        w_wide;
    logic [64:0]        w_mag65;
    logic signed [64:0] w_rnd;
    logic signed [64:0] w_shr;

    // shared adder
    always_comb begin
        w_add_a = '0;
        w_add_b = '0;
        w_cin   = 1'b0;
        unique case (r_state)
            A_ADD: begin
                w_add_a = {r_a[31], r_a};
                if (r_op == ALU_SUB) begin
                    w_add_b = ~{r_b[31], r_b};
                    w_cin   = 1'b1;
                end else begin
                    w_add_b = {r_b[31], r_b};
                end
            end
            A_MUL: begin
                w_add_a = {1'b0, r_hi};
                w_add_b = {1'b0, r_amag};
            end
            A_DIV: begin
                w_add_a = {r_hi, r_lo[31]};
                w_add_b = ~{1'b0, r_bmag};
                w_cin   = 1'b1;
            end
            default: ;
        endcase
        w_sum = {1'b0, w_add_a} + {1'b0, w_add_b} + {33'd0, w_cin};
    end

    assign w_ge    = w_sum[33];
    assign w_amag  = r_a[31] ? (~$unsigned(r_a) + 32'd1) : $unsigned(r_a);
    assign w_bmag  = r_b[31] ? (~$unsigned(r_b) + 32'd1) : $unsigned(r_b);
    assign w_wide  = {32'd0, r_amag} << FRAC_BITS;
    assign w_mag65 = {1'b0, r_hi, r_lo};
    assign w_rnd   = r_prod + HALF;
    assign w_shr   = w_rnd >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_op    <= i_req.op;
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_ovf   <= 1'b0;
                        r_state <= (i_req.op == ALU_ADD || i_req.op == ALU_SUB) ?
                                   A_ADD : A_ABS;
                    end
                end
                A_ADD: begin
                    if (w_sum[32] != w_sum[31]) begin
                        r_value  <= w_sum[32] ? VAL_MIN : VAL_MAX;
                        r_status <= ST_SAT;
                    end else begin
                        r_value  <= w_sum[31:0];
                        r_status <= ST_OK;
                    end
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                A_ABS: begin
                    r_amag <= w_amag;
                    r_bmag <= w_bmag;
                    r_neg  <= r_a[31] ^ r_b[31];
                    r_cnt  <= '0;
                    if (r_op == ALU_MUL) begin
                        r_hi    <= '0;
                        r_lo    <= w_bmag;
                        r_state <= A_MUL;
                    end else if (r_b == 32'sd0) begin
                        // divide by zero: result follows the dividend's sign
                        if (r_a == 32'sd0) begin
                            r_value <= '0;
                        end else begin
                            r_value <= r_a[31] ? VAL_MIN : VAL_MAX;
                        end
                        r_status <= ST_DIV0;
                        r_done   <= 1'b1;
                        r_state  <= A_IDLE;
                    end else begin
                        r_state <= A_PREP;
                    end
                end
                A_PREP: begin
                    // quotient reaches 2^32 when the high half is not below the divisor
                    r_hi <= w_wide[63:32];
                    r_lo <= w_wide[31:0];
                    if (w_wide[63:32] >= r_bmag) begin
                        r_ovf   <= 1'b1;
                        r_state <= A_DFIN;
                    end else begin
                        r_state <= A_DIV;
                    end
                end
                A_DIV: begin
                    r_hi  <= w_ge ? w_sum[31:0] : {r_hi[30:0], r_lo[31]};
                    r_lo  <= {r_lo[30:0], w_ge};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= A_DFIN;
                    end
                end
                A_MUL: begin
                    if (r_lo[0]) begin
                        r_hi <= w_sum[32:1];
                        r_lo <= {w_sum[0], r_lo[31:1]};
                    end else begin
                        r_hi <= {1'b0, r_hi[31:1]};
                        r_lo <= {r_hi[0], r_lo[31:1]};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= A_MNEG;
                    end
                end
                A_MNEG: begin
                    r_prod  <= r_neg ? $signed(~w_mag65 + 65'd1) : $signed(w_mag65);
                    r_state <= A_MRND;
                end
                A_MRND: begin
                    if (w_shr > SMAX) begin
                        r_value  <= VAL_MAX;
                        r_status <= ST_SAT;
                    end else if (w_shr < SMIN) begin
                        r_value  <= VAL_MIN;
                        r_status <= ST_SAT;
                    end else begin
                        r_value  <= w_shr[31:0];
                        r_status <= ST_OK;
                    end
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                A_DFIN: begin
                    if (r_neg) begin
                        if (r_ovf || r_lo > VAL_MIN) begin
                            r_value  <= VAL_MIN;
                            r_status <= ST_SAT;
                        end else begin
                            r_value  <= ~r_lo + 32'd1;
                            r_status <= ST_OK;
                        end
                    end else begin
                        if (r_ovf || r_lo[31]) begin
                            r_value  <= VAL_MAX;
                            r_status <= ST_SAT;
                        end else begin
                            r_value  <= r_lo;
                            r_status <= ST_OK;
                        end
                    end
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.status = r_status;
    assign o_rsp.value  = r_value;

endmodule

/* hdl/rpn_stack_calculator_top.sv */
// ----------------------------------------------------------------------------
// rpn_stack_calculator_top
// Reverse Polish calculator on a bounded stack of signed fixed-point values.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  request   i_in_valid / o_in_ready    i_cmd, i_operand
//  result    o_out_valid / i_out_ready  o_top_value, o_top_valid,
//                                       o_entry_count, o_status
//
//  Push, clear, peek, no-op and underflowed operators finish in the accept
//  cycle; the result is presented on the next cycle.
//  Add/subtract take a single pass through the shared adder. Multiply and
//  divide run a 32-step shift-add or restoring division loop in the shared
//  arithmetic unit at one bit per cycle. Divide by zero returns once the
//  operand magnitudes are taken, and a quotient too large for 32 bits skips the loop.
//  Request ready drops while an operator is in flight, and also when the
//  result register is full and not being drained.
//  Reset clears the entry count, state and result valid; stack RAM contents are not cleared.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_top #(
    parameter int STACK_DEPTH = 64,
    parameter int FRAC_BITS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_operand,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_top_value,
    output logic               o_top_valid,
    output logic [6:0]         o_entry_count,
    output logic [2:0]         o_status
);
    import rpn_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] TWO_CNT   = CNT_W'(2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_ALU,
        S_FIN
    } t_state;

    // The top of stack lives in r_top; the RAM holds the entries below it.
    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic signed [31:0] r_top;
    t_alu_op            r_op;
    logic [2:0]         r_res_status;
    logic               r_out_valid;
    logic signed [31:0] r_top_value;
    logic               r_top_valid;
    logic [6:0]         r_entry_count;
    logic [2:0]         r_status;

    logic               w_in_fire;
    logic               w_out_free;
    logic [CNT_W-1:0]   w_cnt_m1;
    logic [CNT_W-1:0]   w_cnt_m2;
    logic               w_ram_we;
    logic [31:0]        w_ram_rdata;
    t_alu_req           w_alu_req;
    t_alu_rsp           w_alu_rsp;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_cnt_m1   = r_count - CNT_W'(1);
    assign w_cnt_m2   = r_count - TWO_CNT;

    // push spills the old top into the RAM below the new one
    assign w_ram_we = w_in_fire && (i_cmd == CMD_PUSH) && (r_count != '0)
                      && (r_count < DEPTH_CNT);

    rpn_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_cnt_m1[AW-1:0]),
        .i_wdata (r_top),
        .i_raddr (w_cnt_m2[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // entry below the top arrives from the RAM in the cycle after accept
    assign w_alu_req.start = (r_state == S_FETCH);
    assign w_alu_req.op    = r_op;

    rpn_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_alu_req),
        .i_a     ($signed(w_ram_rdata)),
        .i_b     (r_top),
        .o_rsp   (w_alu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        // default reply: stack as it stands
                        r_top_value   <= (r_count != '0) ? r_top : 32'sd0;
                        r_top_valid   <= (r_count != '0);
                        r_entry_count <= 7'(r_count);
                        r_status      <= ST_OK;
                        r_out_valid   <= 1'b1;
                        unique case (i_cmd) inside
                            CMD_PUSH: begin
                                if (r_count >= DEPTH_CNT) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_top         <= i_operand;
                                    r_count       <= r_count + CNT_W'(1);
                                    r_top_value   <= i_operand;
                                    r_top_valid   <= 1'b1;
                                    r_entry_count <= 7'(r_count + CNT_W'(1));
                                end
                            end
                            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                                if (r_count < TWO_CNT) begin
                                    r_status <= ST_UNDER;
                                end else begin
                                    // reply comes later from S_FIN
                                    r_out_valid <= 1'b0;
                                    r_state     <= S_FETCH;
                                    unique case (i_cmd) inside
                                        CMD_ADD: r_op <= ALU_ADD;
                                        CMD_SUB: r_op <= ALU_SUB;
                                        CMD_MUL: r_op <= ALU_MUL;
                                        default: r_op <= ALU_DIV;
                                    endcase
                                end
                            end
                            CMD_CLEAR: begin
                                r_count       <= '0;
                                r_top_value   <= 32'sd0;
                                r_top_valid   <= 1'b0;
                                r_entry_count <= '0;
                            end
                            CMD_PEEK: begin
                                if (r_count == '0) begin
                                    r_status <= ST_PEEK_EMPTY;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_FETCH: begin
                    r_state <= S_ALU;
                end
                S_ALU: begin
                    if (w_alu_rsp.done) begin
                        // result replaces the second entry as the new top
                        r_top        <= $signed(w_alu_rsp.value);
                        r_res_status <= w_alu_rsp.status;
                        r_count      <= w_cnt_m1;
                        r_state      <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_top_value   <= r_top;
                        r_top_valid   <= 1'b1;
                        r_entry_count <= 7'(r_count);
                        r_status      <= r_res_status;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_top_value   = r_top_value;
    assign o_top_valid   = r_top_valid;
    assign o_entry_count = r_entry_count;
    assign o_status      = r_status;

endmodule
